FILE: hw/rtl/tfa_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the tagged FIFO with age expiry.
// No dependencies; used by tfa_cell, tfa_chain and the top level.
package tfa_pkg;

  // Default queue depth
  localparam int DEPTH_DEF = 16;

  // Action codes of an input word
  localparam logic [1:0] ACT_PUSH   = 2'd0;
  localparam logic [1:0] ACT_TAKE   = 2'd1;
  localparam logic [1:0] ACT_EXPIRE = 2'd2;

  // Status codes of a result word
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;

  // Command broadcast to every cell of the row
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_PUSH,
    CMD_KILL,
    CMD_PACK
  } cell_cmd_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PACK,
    S_EMIT
  } state_t;

  // One queue entry
  typedef struct packed {
    logic        valid;
    logic [31:0] id;
    logic [31:0] payload;
    logic [31:0] stamp;
  } slot_t;

  // Row control: command plus request fields seen by every cell
  typedef struct packed {
    cell_cmd_t   cmd;
    logic [31:0] key_id;
    logic [31:0] payload;
    logic [31:0] now_s;
    logic [31:0] max_age;
  } chain_ctl_t;

  // Flags and data of the cell under the scan pointer
  typedef struct packed {
    logic        hit;
    logic        match;
    logic [31:0] id;
    logic [31:0] payload;
  } rd_t;

endpackage

FILE: hw/rtl/tagged_fifo_with_age_expiry.sv
`timescale 1ns / 1ps
// Tagged FIFO with age expiry: sequencer, result registers and the cell row.
// Depends on tfa_pkg and tfa_chain.
//
//  channel | handshake            | word
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_ready  | action, msg_id, payload, max_age, now_seconds
//  out     | out_valid / out_ready| status, taken_id, taken_payload,
//          |                      | aged_count, occupancy
//
// Flow: push and unused actions go from accept straight to the result stage. Take
// walks the row one cell per cycle up to the match (or up to the count), then
// closes the gap one cell per cycle. Expire scans all count entries, then
// compacts. The scan reads a single cell at a time through the read-out.
// Reset clears the valid bits, the count and the output valid flag; no clearing
// pass. in_ready is high when idle, also while a result waits in the output
// register; a finished result waits until the register frees up.
module tagged_fifo_with_age_expiry #(
  parameter int DEPTH = tfa_pkg::DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1),
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       action,
  input  logic [31:0]      msg_id,
  input  logic [31:0]      payload,
  input  logic [31:0]      max_age,
  input  logic [31:0]      now_seconds,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       status,
  output logic [31:0]      taken_id,
  output logic [31:0]      taken_payload,
  output logic [CNT_W-1:0] aged_count,
  output logic [CNT_W-1:0] occupancy
);
  import tfa_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic             op_take, op_take_next;
  logic [31:0]      req_id, req_id_next;
  logic [31:0]      req_max_age, req_max_age_next;
  logic [31:0]      req_now, req_now_next;
  logic [1:0]       res_status, res_status_next;
  logic [31:0]      res_id, res_id_next;
  logic [31:0]      res_pay, res_pay_next;
  logic [CNT_W-1:0] res_exp, res_exp_next;
  logic             out_valid_next;
  logic             out_load;

  chain_ctl_t       ctl;
  logic [CNT_W-1:0] sel;
  rd_t              rd;
  logic             packed_ok;

  tfa_chain #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W),
    .IDX_W (IDX_W)
  ) u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sel       (sel),
    .rd_idx    (idx[IDX_W-1:0]),
    .rd        (rd),
    .packed_ok (packed_ok)
  );

  assign in_ready = (state == S_IDLE);

  // Sequencer: next state, row command and result capture
  always_comb begin
    state_next       = state;
    count_next       = count;
    idx_next         = idx;
    op_take_next     = op_take;
    req_id_next      = req_id;
    req_max_age_next = req_max_age;
    req_now_next     = req_now;
    res_status_next  = res_status;
    res_id_next      = res_id;
    res_pay_next     = res_pay;
    res_exp_next     = res_exp;
    out_valid_next   = out_valid && !out_ready;
    out_load         = 1'b0;
    ctl.cmd          = CMD_HOLD;
    ctl.key_id       = req_id;
    ctl.payload      = payload;
    ctl.now_s        = req_now;
    ctl.max_age      = req_max_age;
    sel              = idx;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_status_next = ST_DONE;
          res_id_next     = 32'd0;
          res_pay_next    = 32'd0;
          res_exp_next    = '0;
          idx_next        = '0;
          case (action)
            ACT_PUSH: begin
              if (count == CNT_W'(DEPTH)) begin
                res_status_next = ST_FULL;
              end else begin
                ctl.cmd    = CMD_PUSH;
                ctl.key_id = msg_id;
                ctl.now_s  = now_seconds;
                sel        = count;
                count_next = count + 1'b1;
              end
              state_next = S_EMIT;
            end
            ACT_TAKE: begin
              req_id_next  = msg_id;
              op_take_next = 1'b1;
              state_next   = S_SCAN;
            end
            ACT_EXPIRE: begin
              req_max_age_next = max_age;
              req_now_next     = now_seconds;
              op_take_next     = 1'b0;
              state_next       = S_SCAN;
            end
            default: begin
              state_next = S_EMIT;
            end
          endcase
        end
      end

      // walk the row from the oldest cell
      S_SCAN: begin
        if (idx == count) begin
          if (op_take) begin
            res_status_next = ST_NOMATCH;
            state_next      = S_EMIT;
          end else begin
            count_next = count - res_exp;
            state_next = S_PACK;
          end
        end else if (op_take) begin
          if (rd.hit) begin
            res_id_next  = rd.id;
            res_pay_next = rd.payload;
            ctl.cmd      = CMD_KILL;
            count_next   = count - 1'b1;
            state_next   = S_PACK;
          end else begin
            idx_next = idx + 1'b1;
          end
        end else begin
          if (rd.match) begin
            ctl.cmd      = CMD_KILL;
            res_exp_next = res_exp + 1'b1;
          end
          idx_next = idx + 1'b1;
        end
      end

      // holes bubble up one cell per cycle
      S_PACK: begin
        ctl.cmd = CMD_PACK;
        if (packed_ok) begin
          state_next = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!out_valid || out_ready) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // Request, result and output word registers
  always_ff @(posedge clk) begin
    idx         <= idx_next;
    op_take     <= op_take_next;
    req_id      <= req_id_next;
    req_max_age <= req_max_age_next;
    req_now     <= req_now_next;
    res_status  <= res_status_next;
    res_id      <= res_id_next;
    res_pay     <= res_pay_next;
    res_exp     <= res_exp_next;
    if (out_load) begin
      status        <= res_status;
      taken_id      <= res_id;
      taken_payload <= res_pay;
      aged_count    <= res_exp;
      occupancy     <= count;
    end
  end

endmodule

FILE: hw/rtl/tfa_cell.sv
`timescale 1ns / 1ps
// One queue cell: holds an entry, shifts toward the old end to close gaps.
// Depends on tfa_pkg.
module tfa_cell (
  input  logic               clk,
  input  logic               rst,
  input  tfa_pkg::chain_ctl_t ctl,
  input  logic               sel,
  input  tfa_pkg::slot_t     up,
  input  logic               low_valid,
  output tfa_pkg::slot_t     q,
  output logic               hit,
  output logic               match
);
  import tfa_pkg::*;

  logic        q_valid;
  logic [31:0] q_id;
  logic [31:0] q_payload;
  logic [31:0] q_stamp;
  slot_t       slot_next;
  logic [32:0] deadline;

  assign q = '{valid: q_valid, id: q_id, payload: q_payload, stamp: q_stamp};

  // Take match: any entry for id 0, else equal id
  assign hit = q_valid && ((ctl.key_id == 32'd0) || (q_id == ctl.key_id));

  // Expire match: any entry for max_age 0, else stamp + max_age < now, no wrap
  assign deadline = {1'b0, q_stamp} + {1'b0, ctl.max_age};
  assign match = q_valid && ((ctl.max_age == 32'd0) || (deadline < {1'b0, ctl.now_s}));

  // Next entry
  always_comb begin
    slot_next = q;
    case (ctl.cmd)
      CMD_PUSH: begin
        if (sel) begin
          slot_next = '{valid: 1'b1, id: ctl.key_id, payload: ctl.payload,
                        stamp: ctl.now_s};
        end
      end
      CMD_KILL: begin
        if (sel) begin
          slot_next.valid = 1'b0;
        end
      end
      CMD_PACK: begin
        // empty cell pulls from above; valid cell over a hole moves down
        if (!q_valid) begin
          slot_next = up;
        end else if (!low_valid) begin
          slot_next.valid = 1'b0;
        end
      end
      default: begin
        slot_next = q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else begin
      q_valid <= slot_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    q_id      <= slot_next.id;
    q_payload <= slot_next.payload;
    q_stamp   <= slot_next.stamp;
  end

endmodule

FILE: hw/rtl/tfa_chain.sv
`timescale 1ns / 1ps
// Row of DEPTH queue cells, oldest entry in cell 0, plus scan read-out.
// Depends on tfa_pkg and tfa_cell.
module tfa_chain #(
  parameter int DEPTH = tfa_pkg::DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1),
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  tfa_pkg::chain_ctl_t ctl,
  input  logic [CNT_W-1:0]    sel,
  input  logic [IDX_W-1:0]    rd_idx,
  output tfa_pkg::rd_t        rd,
  output logic                packed_ok
);
  import tfa_pkg::*;

  slot_t             q     [DEPTH];
  logic [DEPTH-1:0]  hit;
  logic [DEPTH-1:0]  match;
  logic [DEPTH-1:0]  gap;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    slot_t up;
    logic  low_valid;
    logic  sel_i;

    if (i == DEPTH - 1) begin : g_top
      assign up = '0;
    end else begin : g_mid
      assign up = q[i+1];
    end

    // cell 0 has nothing below; a valid cell above an empty one is a gap
    if (i == 0) begin : g_bot
      assign low_valid = 1'b1;
      assign gap[i]    = 1'b0;
    end else begin : g_upper
      assign low_valid = q[i-1].valid;
      assign gap[i]    = q[i].valid && !q[i-1].valid;
    end

    assign sel_i = (sel == CNT_W'(i));

    tfa_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .sel       (sel_i),
      .up        (up),
      .low_valid (low_valid),
      .q         (q[i]),
      .hit       (hit[i]),
      .match     (match[i])
    );
  end

  // Row is packed when no valid entry sits over a hole
  assign packed_ok = ~|gap;

  // Cell under the scan pointer
  assign rd.hit     = hit[rd_idx];
  assign rd.match   = match[rd_idx];
  assign rd.id      = q[rd_idx].id;
  assign rd.payload = q[rd_idx].payload;

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for tagged_fifo_with_age_expiry: directed and random words,
// a queue scoreboard class predicting every result. Depends on tfa_pkg and the RTL.
module tb_top;
  import tfa_pkg::*;

  localparam int Q_DEPTH        = DEPTH_DEF;
  localparam int CNT_W          = $clog2(Q_DEPTH + 1);
  localparam int RANDOM_WORDS   = 750;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 60;
  localparam int WATCHDOG_LIMIT = 5000;
  // action 3 has no code in the package; the block ignores it
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [31:0] id;
    logic [31:0] payload;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [31:0]      taken_id;
    logic [31:0]      taken_payload;
    logic [CNT_W-1:0] aged_count;
    logic [CNT_W-1:0] occupancy;
  } result_t;

  // Queue model plus the list of result words still owed by the block
  class queue_scoreboard;
    entry_t  held[$];
    result_t owed[$];
    int errors;
    int words_in;
    int words_out;
    int full_rejects;
    int no_match;
    int aged_out;

    task report(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    // predict the result word of one accepted input word
    function void note_input(input logic [1:0] act, input logic [31:0] id,
                             input logic [31:0] pl, input logic [31:0] age,
                             input logic [31:0] now);
      result_t r;
      longint  limit;
      int      i;
      bit      found;
      r = '0;
      words_in++;
      case (act)
        ACT_PUSH: begin
          if (held.size() >= Q_DEPTH) begin
            r.status = ST_FULL;
            full_rejects++;
          end else begin
            held.push_back('{id: id, payload: pl, stamp: now});
          end
        end
        ACT_TAKE: begin
          found = 1'b0;
          for (i = 0; i < held.size() && !found; i++) begin
            if (id == 32'd0 || held[i].id == id) begin
              r.taken_id      = held[i].id;
              r.taken_payload = held[i].payload;
              held.delete(i);
              found = 1'b1;
            end
          end
          if (!found) begin
            r.status = ST_NOMATCH;
            no_match++;
          end
        end
        ACT_EXPIRE: begin
          // limit is signed and may go below zero; stamps count as non-negative
          limit = $signed({32'd0, now}) - $signed({32'd0, age});
          i = 0;
          while (i < held.size()) begin
            if (age == 32'd0 || $signed({32'd0, held[i].stamp}) < limit) begin
              held.delete(i);
              r.aged_count++;
              aged_out++;
            end else begin
              i++;
            end
          end
        end
        default: ;
      endcase
      r.occupancy = CNT_W'(held.size());
      owed.push_back(r);
    endfunction

    // compare one accepted result word with the oldest prediction
    task check_result(input result_t got);
      result_t want;
      words_out++;
      if (owed.size() == 0) begin
        report($sformatf("result word with nothing owed: %p", got));
      end else begin
        want = owed.pop_front();
        if (got.status !== want.status)
          report($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.taken_id !== want.taken_id)
          report($sformatf("taken_id got %h want %h", got.taken_id, want.taken_id));
        if (got.taken_payload !== want.taken_payload)
          report($sformatf("taken_payload got %h want %h",
                           got.taken_payload, want.taken_payload));
        if (got.aged_count !== want.aged_count)
          report($sformatf("aged_count got %0d want %0d",
                           got.aged_count, want.aged_count));
        if (got.occupancy !== want.occupancy)
          report($sformatf("occupancy got %0d want %0d", got.occupancy, want.occupancy));
      end
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [1:0]       action;
  logic [31:0]      msg_id;
  logic [31:0]      payload;
  logic [31:0]      max_age;
  logic [31:0]      now_seconds;
  logic             out_valid;
  logic             out_ready;
  logic [1:0]       status;
  logic [31:0]      taken_id;
  logic [31:0]      taken_payload;
  logic [CNT_W-1:0] aged_count;
  logic [CNT_W-1:0] occupancy;

  queue_scoreboard sb = new();
  bit          hold_req;
  int          idle_cycles;
  int          tx_steady;
  int          rx_steady;
  int          rx_wait;
  logic [31:0] now_clk;

  tagged_fifo_with_age_expiry dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .msg_id        (msg_id),
    .payload       (payload),
    .max_age       (max_age),
    .now_seconds   (now_seconds),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .taken_id      (taken_id),
    .taken_payload (taken_payload),
    .aged_count    (aged_count),
    .occupancy     (occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one input word at a falling edge, hold it until accepted
  task automatic send_word(input logic [1:0] a, input logic [31:0] id,
                           input logic [31:0] pl, input logic [31:0] age,
                           input logic [31:0] now);
    int gap;
    action      = a;
    msg_id      = id;
    payload     = pl;
    max_age     = age;
    now_seconds = now;
    in_valid    = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(a, id, pl, age, now);
    @(negedge clk);
    if (tx_steady > 0) begin
      tx_steady--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 99) < 3) tx_steady = $urandom_range(20, 50);
      gap = idle_gap();
    end
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // directed words: empty queue, unused action, fill to full, match cases, age rules
  task automatic run_directed();
    int i;
    logic [31:0] id;
    logic [31:0] st;
    send_word(ACT_TAKE, 32'd0, $urandom(), $urandom(), 32'd0);
    send_word(ACT_EXPIRE, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_word(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (i = 0; i < Q_DEPTH; i++) begin
      id = (i == 0) ? 32'd0 : (i == 1) ? 32'hFFFF_FFFF : 32'(i % 3 + 1);
      st = (i == 2) ? 32'hFFFF_FFFF : (i == 3) ? 32'd0 : 32'(10 * i + 5);
      send_word(ACT_PUSH, id, (i == 0) ? 32'd0 : ~32'(i), $urandom(), st);
    end
    send_word(ACT_PUSH, 32'd9, 32'h5A5A_A5A5, 32'd0, 32'd500);
    send_word(ACT_TAKE, 32'h1234_5678, 32'd0, 32'd0, 32'd0);
    send_word(ACT_TAKE, 32'd2, 32'd0, 32'd0, 32'd0);
    send_word(ACT_TAKE, 32'd0, 32'd0, 32'd0, 32'd0);
    // limit below zero: nothing goes
    send_word(ACT_EXPIRE, 32'd0, 32'd0, 32'd200, 32'd100);
    // stamps under 55 go, the future stamp stays
    send_word(ACT_EXPIRE, 32'd0, 32'd0, 32'd45, 32'd100);
    // zero age clears everything
    send_word(ACT_EXPIRE, 32'd0, 32'd0, 32'd0, 32'd0);
  endtask

  // random words steered by the model so takes hit and the queue swings full/empty
  task automatic run_random(input int n);
    int k;
    int occ;
    int pick;
    int push_pct;
    int sel;
    logic [1:0]  a;
    logic [31:0] id;
    logic [31:0] age;
    for (k = 0; k < n; k++) begin
      // halfway: receiver stalls long while words keep coming
      if (k == n / 2) hold_req = 1'b1;
      if ($urandom_range(0, 99) < 3) now_clk = $urandom();
      else now_clk = now_clk + $urandom_range(0, 4);
      occ      = sb.held.size();
      push_pct = (occ < 4) ? 65 : (occ > 12) ? 25 : 45;
      pick     = $urandom_range(0, 99);
      sel      = $urandom_range(0, 99);
      id       = $urandom();
      age      = $urandom();
      if (pick < push_pct) begin
        a = ACT_PUSH;
        if (sel < 55) id = $urandom_range(1, 8);
        else if (sel < 65) id = 32'd0;
      end else if (pick < push_pct + 35) begin
        a = ACT_TAKE;
        if (sel < 40) id = 32'd0;
        else if (sel < 80 && occ > 0) id = sb.held[$urandom_range(0, occ - 1)].id;
        else if (sel < 90) id = $urandom_range(1, 8);
      end else if (pick < 96) begin
        a = ACT_EXPIRE;
        if (sel < 10) age = 32'd0;
        else if (sel < 25) age = now_clk + $urandom_range(1, 100);
        else if (sel < 35) age = $urandom();
        else age = $urandom_range(1, 40);
      end else begin
        a = ACT_UNUSED;
      end
      send_word(a, id, $urandom(), age, now_clk);
    end
  endtask

  // receiver: random stalls, steady stretches, one long hold on request
  initial begin
    out_ready = 1'b0;
    rx_wait   = 0;
    rx_steady = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (rx_wait > 0) begin
        out_ready = 1'b0;
        rx_wait--;
      end else begin
        out_ready = 1'b1;
        if (rx_steady > 0) rx_steady--;
        else if ($urandom_range(0, 99) < 3) rx_steady = $urandom_range(30, 80);
        else if ($urandom_range(0, 99) < 35) rx_wait = idle_gap();
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{status, taken_id, taken_payload, aged_count, occupancy});
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, idle_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // main sequence
  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    action      = ACT_PUSH;
    msg_id      = '0;
    payload     = '0;
    max_age     = '0;
    now_seconds = '0;
    hold_req    = 1'b0;
    tx_steady   = 0;
    now_clk     = 32'd1000;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    run_directed();
    run_random(RANDOM_WORDS);
    in_valid = 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.owed.size() != 0) sb.report($sformatf("%0d result words never came", sb.owed.size()));
    $display("Covered %0d input words and %0d result words, including one long output stall.",
             sb.words_in, sb.words_out);
    $display("Full rejects %0d, takes without match %0d, entries aged out %0d, mismatches %0d.",
             sb.full_rejects, sb.no_match, sb.aged_out, sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
